FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked property, also checked during reset
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/cpiv_pkg.sv
// Types and constants of the cascaded PI position/velocity/current controller.
// No dependencies.
`timescale 1ns / 1ps

package cpiv_pkg;

  localparam logic [1:0] LOOP_CUR = 2'd0;
  localparam logic [1:0] LOOP_VEL = 2'd1;
  localparam logic [1:0] LOOP_POS = 2'd2;

  localparam int unsigned CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POS_PROP_GAIN  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POS_INT_GAIN   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VEL_PROP_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VEL_INT_GAIN   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUR_PROP_GAIN  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUR_INT_GAIN   = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd6;

  localparam logic [15:0] INTEGRAL_LIMIT_RESET = 16'd200;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] position_meas;
    logic [15:0] position_target;
    logic [15:0] velocity_meas;
    logic [11:0] current_meas;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         loop_tag;
    logic signed [15:0] demand;
    logic               clipped;
  } rsp_word_t;

  typedef struct packed {
    logic signed [15:0] pos_prop_gain;
    logic signed [15:0] pos_int_gain;
    logic signed [15:0] vel_prop_gain;
    logic signed [15:0] vel_int_gain;
    logic signed [15:0] cur_prop_gain;
    logic signed [15:0] cur_int_gain;
    logic [15:0]        integral_limit;
  } gains_t;

  typedef struct packed {
    logic signed [31:0] pos_integrator;
    logic signed [31:0] vel_integrator;
    logic signed [31:0] cur_integrator;
    logic signed [15:0] vel_target;
    logic signed [15:0] cur_target;
    logic signed [15:0] motor_drive;
  } pi_state_t;

endpackage

FILE: hw/rtl/cpiv_cfg_regs.sv
// Gain and limit register file of the controller.
// Depends on cpiv_pkg.
`timescale 1ns / 1ps

module cpiv_cfg_regs
  import cpiv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [15:0]                wr_data,
  output gains_t                     gains
);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.pos_prop_gain  <= '0;
      gains.pos_int_gain   <= '0;
      gains.vel_prop_gain  <= '0;
      gains.vel_int_gain   <= '0;
      gains.cur_prop_gain  <= '0;
      gains.cur_int_gain   <= '0;
      gains.integral_limit <= INTEGRAL_LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_POS_PROP_GAIN:  gains.pos_prop_gain  <= wr_data;
        REG_POS_INT_GAIN:   gains.pos_int_gain   <= wr_data;
        REG_VEL_PROP_GAIN:  gains.vel_prop_gain  <= wr_data;
        REG_VEL_INT_GAIN:   gains.vel_int_gain   <= wr_data;
        REG_CUR_PROP_GAIN:  gains.cur_prop_gain  <= wr_data;
        REG_CUR_INT_GAIN:   gains.cur_int_gain   <= wr_data;
        REG_INTEGRAL_LIMIT: gains.integral_limit <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cpiv_pi_datapath.sv
// One PI step: error, integrator update, gain products, scaling and clamp.
// Depends on cpiv_pkg.
`timescale 1ns / 1ps

module cpiv_pi_datapath
  import cpiv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DEMAND_WIDTH   = 16
) (
  input  cmd_word_t cmd,
  input  gains_t    gains,
  input  pi_state_t state,
  output pi_state_t state_next,
  output rsp_word_t rsp,
  output logic      legal
);

  localparam logic signed [48:0] DMAX = (49'sd1 <<< (DEMAND_WIDTH - 1)) - 49'sd1;
  localparam logic signed [48:0] DMIN = -DMAX - 49'sd1;

  logic signed [17:0] err;
  logic signed [31:0] integ;
  logic signed [15:0] kp;
  logic signed [15:0] ki;
  logic               in_range;
  logic signed [32:0] sum;
  logic signed [31:0] integ_new;
  logic               integ_clip;
  logic signed [33:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [48:0] acc;
  logic signed [48:0] scaled;
  logic signed [48:0] clamped;
  logic               demand_clip;

  always_comb begin
    legal = 1'b1;
    err   = $signed({6'b0, cmd.current_meas})
            - $signed({{2{state.cur_target[15]}}, state.cur_target});
    integ = state.cur_integrator;
    kp    = gains.cur_prop_gain;
    ki    = gains.cur_int_gain;
    case (cmd.mode)
      LOOP_CUR: ;
      LOOP_VEL: begin
        err   = $signed({2'b0, cmd.velocity_meas})
                - $signed({{2{state.vel_target[15]}}, state.vel_target});
        integ = state.vel_integrator;
        kp    = gains.vel_prop_gain;
        ki    = gains.vel_int_gain;
      end
      LOOP_POS: begin
        err   = $signed({2'b0, cmd.position_meas}) - $signed({2'b0, cmd.position_target});
        integ = state.pos_integrator;
        kp    = gains.pos_prop_gain;
        ki    = gains.pos_int_gain;
      end
      default: legal = 1'b0;
    endcase
  end

  always_comb begin
    in_range   = integ < $signed({16'b0, gains.integral_limit});
    sum        = 33'(integ) + 33'(err);
    integ_new  = sum[31:0];
    integ_clip = 1'b0;
    if (!in_range) begin
      integ_new  = '0;
      integ_clip = 1'b1;
    end else if (sum[32] != sum[31]) begin
      integ_new  = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      integ_clip = 1'b1;
    end
  end

  always_comb begin
    prod_p      = 34'(kp) * 34'(err);
    prod_i      = 48'(ki) * 48'(integ_new);
    acc         = 49'(prod_p) + 49'(prod_i);
    scaled      = acc >>> GAIN_FRAC_BITS;
    clamped     = scaled;
    demand_clip = 1'b0;
    if (scaled > DMAX) begin
      clamped     = DMAX;
      demand_clip = 1'b1;
    end else if (scaled < DMIN) begin
      clamped     = DMIN;
      demand_clip = 1'b1;
    end
  end

  always_comb begin
    rsp.loop_tag = cmd.mode;
    rsp.demand   = clamped[15:0];
    rsp.clipped  = integ_clip | demand_clip;
    state_next   = state;
    case (cmd.mode)
      LOOP_CUR: begin
        state_next.cur_integrator = integ_new;
        state_next.motor_drive    = clamped[15:0];
      end
      LOOP_VEL: begin
        state_next.vel_integrator = integ_new;
        state_next.cur_target     = clamped[15:0];
      end
      LOOP_POS: begin
        state_next.pos_integrator = integ_new;
        state_next.vel_target     = clamped[15:0];
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/cascaded_piv_controller.sv
// Top level of the cascaded PI position/velocity/current controller.
// Depends on cpiv_pkg, cpiv_cfg_regs and cpiv_pi_datapath.
//
//   channel | handshake            | word
//   cmd     | cmd_valid, cmd_stall | cmd_word_t: loop select, sensor readings, position target
//   rsp     | rsp_valid, rsp_stall | rsp_word_t: loop tag, demand, clip flag
//   cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data: gain and limit writes
//
// A command passes the input register, then the single-pass PI datapath into
// the response register. One word per cycle while the response is not stalled.
// Synchronous reset clears gains, limit (to 200), integrators and demands.
// A stalled response holds the datapath; a mode 3 word is dropped silently.
`timescale 1ns / 1ps

module cascaded_piv_controller
  import cpiv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int DEMAND_WIDTH   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  cmd_word_t                  cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output rsp_word_t                  rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);

  gains_t    gains;
  cmd_word_t cmd_q;
  logic      cmd_q_valid;
  pi_state_t state;
  pi_state_t state_next;
  rsp_word_t rsp_next;
  logic      legal;
  logic      advance;
  logic      accept;

  assign cfg_ready = 1'b1;

  cpiv_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .gains    (gains)
  );

  cpiv_pi_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DEMAND_WIDTH   (DEMAND_WIDTH)
  ) u_dp (
    .cmd        (cmd_q),
    .gains      (gains),
    .state      (state),
    .state_next (state_next),
    .rsp        (rsp_next),
    .legal      (legal)
  );

  assign advance   = cmd_q_valid & (!legal | !rsp_valid | !rsp_stall);
  assign cmd_stall = cmd_q_valid & !advance;
  assign accept    = cmd_valid & !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (accept) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      rsp_valid <= 1'b0;
    end else if (advance && legal) begin
      state     <= state_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && legal) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: hw/rtl/cpiv_checker.sv
// Port-level checks of the controller, bound to the top level.
// Depends on cpiv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpiv_checker
  import cpiv_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input cmd_word_t cmd,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp,
  input logic      cfg_ready
);

  `ASSERT_CLK_RST(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
  `ASSERT_CLK_RST(a_cmd_hold, clk, rst, cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
  `ASSERT_CLK_RST(a_stall_cause, clk, rst, cmd_stall |-> rsp_valid && rsp_stall)
  `ASSERT_CLK_RST(a_tag_legal, clk, rst, rsp_valid |-> rsp.loop_tag <= LOOP_POS)
  `ASSERT_CLK(a_reset_idle, clk, rst |=> !rsp_valid && !cmd_stall && cfg_ready)

endmodule

bind cascaded_piv_controller cpiv_checker u_cpiv_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);
